// ===== src/swts_pkg.sv =====
package swts_pkg;

    localparam int PRIO_W   = 16;
    localparam int WEIGHT_W = 16;
    localparam int PORT_W   = 16;
    localparam int TAG_W    = 8;
    localparam int RAND_W   = 32;
    localparam int ACT_W    = 2;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DRAW  = 2'd2;

    typedef struct packed {
        logic [PRIO_W-1:0]   priority_val;
        logic [WEIGHT_W-1:0] weight;
        logic [PORT_W-1:0]   port;
        logic [TAG_W-1:0]    tag;
        logic                kind;
    } t_rec;

endpackage

// ===== src/srv_weighted_target_selector.sv =====
// weighted service record selector
// input channel: i_in_valid / o_in_stall carry one action per transfer:
//   clear empties the table, load appends a record, draw picks and removes one.
// output channel: o_out_valid / i_out_stall carry one result per transfer:
//   a chosen record, none_left for a draw on an empty table, or table_full
//   for a load that found no room. clear and stored loads give no result.
// i_cfg_we / i_cfg_data write secure_only; when set, unsigned loads are dropped.
// after a clear or a stored or dropped load the next item can follow at once;
// a load on a full table and a draw on an empty one pass the emit state first.
// a draw runs through the transfer, a first scan of the record memory, the
// scaling multiply, a second scan, which stops at the chosen record (skipped
// when the group's weights sum to zero), together with the compaction of the
// records behind it, and the hand-over of the result to the output register;
// the scans read one record at a time through the single read port of the memory.
// the result register frees the input side: a new item is taken while a
// result still waits; a stalled result holds until the receiver takes it and
// a finished draw waits in its last state for the register to free up.
// synchronous reset empties the table, clears secure_only and drops any
// pending result; memory contents are not cleared.
module srv_weighted_target_selector #(
    parameter int MAX_RECORDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_rec_priority,
    input  logic [15:0] i_rec_weight,
    input  logic [15:0] i_rec_port,
    input  logic [7:0]  i_rec_tag,
    input  logic        i_rec_kind,
    input  logic        i_rec_signed,
    input  logic [31:0] i_random_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_none_left,
    output logic [15:0] o_out_priority,
    output logic [15:0] o_out_weight,
    output logic [15:0] o_out_port,
    output logic [7:0]  o_out_tag,
    output logic        o_out_kind,
    output logic        o_table_full
);

    localparam int IDX_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int SUM_W  = swts_pkg::WEIGHT_W + CNT_W;
    localparam int PROD_W = swts_pkg::RAND_W + SUM_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN1 = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_SCAN2 = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    swts_pkg::t_rec r_mem [MAX_RECORDS];
    swts_pkg::t_rec r_rd_data;
    swts_pkg::t_rec r_sel;
    swts_pkg::t_rec mem_wdata;
    swts_pkg::t_rec in_rec;

    logic [2:0]                   r_state;
    logic [CNT_W-1:0]             r_count;
    logic                         r_secure_only;
    logic [CNT_W-1:0]             r_idx;
    logic                         r_vld;
    logic [IDX_W-1:0]             r_pidx;
    logic [IDX_W-1:0]             r_sel_idx;
    logic [swts_pkg::PRIO_W-1:0]  r_best;
    logic [SUM_W-1:0]             r_sum;
    logic [SUM_W-1:0]             r_rem;
    logic [swts_pkg::RAND_W-1:0]  r_rnd;
    logic [PROD_W-1:0]            r_prod;
    logic                         r_res_none;
    logic                         r_res_full;
    logic                         r_out_valid;
    logic                         r_out_none;
    logic                         r_out_full;
    swts_pkg::t_rec               r_out_rec;

    logic             accept;
    logic             store_ok;
    logic             is_full;
    logic             scanning;
    logic             issue;
    logic             emit;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] rd_addr;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign store_ok   = !(r_secure_only && !i_rec_signed);
    assign is_full    = (r_count >= CNT_W'(MAX_RECORDS));
    assign scanning   = (r_state == S_SCAN1) || (r_state == S_SCAN2) || (r_state == S_SHIFT);
    assign issue      = scanning && (r_idx < r_count);
    assign rd_addr    = r_idx[IDX_W-1:0];
    assign emit       = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    assign in_rec.priority_val = i_rec_priority;
    assign in_rec.weight       = i_rec_weight;
    assign in_rec.port         = i_rec_port;
    assign in_rec.tag          = i_rec_tag;
    assign in_rec.kind         = i_rec_kind;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[IDX_W-1:0];
        mem_wdata = in_rec;
        if (accept && (i_action == swts_pkg::ACT_LOAD) && store_ok && !is_full) begin
            mem_we = 1'b1;
        end
        // compaction: entry read last cycle moves down one place
        if ((r_state == S_SHIFT) && r_vld) begin
            mem_we    = 1'b1;
            mem_waddr = r_pidx - IDX_W'(1);
            mem_wdata = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_secure_only <= 1'b0;
            r_idx         <= '0;
            r_vld         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_secure_only <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            r_vld <= issue;
            if (issue) begin
                r_pidx <= r_idx[IDX_W-1:0];
                r_idx  <= r_idx + CNT_W'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_rnd <= i_random_word;
                        unique case (i_action)
                            swts_pkg::ACT_CLEAR: begin
                                r_count <= '0;
                            end
                            swts_pkg::ACT_LOAD: begin
                                if (store_ok) begin
                                    if (is_full) begin
                                        r_sel      <= '0;
                                        r_res_full <= 1'b1;
                                        r_res_none <= 1'b0;
                                        r_state    <= S_EMIT;
                                    end else begin
                                        r_count <= r_count + CNT_W'(1);
                                    end
                                end
                            end
                            swts_pkg::ACT_DRAW: begin
                                if (r_count == '0) begin
                                    r_sel      <= '0;
                                    r_res_none <= 1'b1;
                                    r_res_full <= 1'b0;
                                    r_state    <= S_EMIT;
                                end else begin
                                    r_idx   <= '0;
                                    r_state <= S_SCAN1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN1: begin
                    // lowest priority, its first record and the group weight sum
                    if (r_vld) begin
                        if ((r_pidx == '0) || (r_rd_data.priority_val < r_best)) begin
                            r_best    <= r_rd_data.priority_val;
                            r_sum     <= SUM_W'(r_rd_data.weight);
                            r_sel_idx <= r_pidx;
                            r_sel     <= r_rd_data;
                        end else if (r_rd_data.priority_val == r_best) begin
                            r_sum <= r_sum + SUM_W'(r_rd_data.weight);
                        end
                    end
                    if (!issue && !r_vld) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_rnd) * PROD_W'(r_sum + SUM_W'(1));
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    if (r_sum == '0) begin
                        r_idx   <= CNT_W'(r_sel_idx) + CNT_W'(1);
                        r_state <= S_SHIFT;
                    end else begin
                        r_rem   <= r_prod[PROD_W-1 -: SUM_W];
                        r_idx   <= '0;
                        r_state <= S_SCAN2;
                    end
                end
                S_SCAN2: begin
                    if (r_vld && (r_rd_data.priority_val == r_best)) begin
                        // remainder would reach zero or below on this record;
                        // the read already in flight is the first one to move down
                        if (r_rem <= SUM_W'(r_rd_data.weight)) begin
                            r_sel     <= r_rd_data;
                            r_sel_idx <= r_pidx;
                            r_state   <= S_SHIFT;
                        end else begin
                            r_rem <= r_rem - SUM_W'(r_rd_data.weight);
                        end
                    end else if (!issue && !r_vld) begin
                        r_idx   <= CNT_W'(r_sel_idx) + CNT_W'(1);
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (!issue && !r_vld) begin
                        r_count    <= r_count - CNT_W'(1);
                        r_res_none <= 1'b0;
                        r_res_full <= 1'b0;
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_rec  <= r_sel;
            r_out_none <= r_res_none;
            r_out_full <= r_res_full;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_none_left    = r_out_none;
    assign o_table_full   = r_out_full;
    assign o_out_priority = r_out_rec.priority_val;
    assign o_out_weight   = r_out_rec.weight;
    assign o_out_port     = r_out_rec.port;
    assign o_out_tag      = r_out_rec.tag;
    assign o_out_kind     = r_out_rec.kind;

endmodule

// ===== src/swts_chk.sv =====
module swts_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_action,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_none_left,
    input logic [15:0] o_out_priority,
    input logic [15:0] o_out_weight,
    input logic [15:0] o_out_port,
    input logic [7:0]  o_out_tag,
    input logic        o_out_kind,
    input logic        o_table_full
);

    logic res_zero;
    assign res_zero = (o_out_priority == '0) && (o_out_weight == '0) &&
                      (o_out_port == '0) && (o_out_tag == '0) && !o_out_kind;

    // a stalled result holds until the transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_none_left) &&
        $stable(o_table_full) && $stable(o_out_priority) && $stable(o_out_port) &&
        $stable(o_out_weight) && $stable(o_out_tag) && $stable(o_out_kind))
        else $error("result changed while stalled");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_none_left && o_table_full))
        else $error("none_left and table_full together");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_none_left || o_table_full) |-> res_zero)
        else $error("flagged result carries record data");

    // an accepted draw always stalls the input side in the cycle after its transfer
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_action == swts_pkg::ACT_DRAW) |=> o_in_stall)
        else $error("draw did not hold off the next item");

endmodule

bind srv_weighted_target_selector swts_chk u_swts_chk (.*);
